/* rtl/gyro_report_decode_smooth_core_assert.svh */
// assertion macros used by the checker file
`ifndef GYRO_REPORT_DECODE_SMOOTH_CORE_ASSERT_SVH
`define GYRO_REPORT_DECODE_SMOOTH_CORE_ASSERT_SVH

// concurrent check, off while reset is held
`define GRDS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("grds check failed");

// concurrent check that also runs through reset
`define GRDS_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("grds check failed during reset");

`endif

/* rtl/grds_pkg.sv */
`default_nettype none

package grds_pkg;

    // reading and rate format
    localparam int READING_BITS       = 14;
    localparam int RATE_FRACTION_BITS = 4;
    localparam int RATE_BITS          = 17;
    localparam int AXES               = 3;
    localparam int BYTE_BITS          = 8;

    // axis order inside arrays
    localparam int AXIS_ROLL  = 0;
    localparam int AXIS_PITCH = 1;
    localparam int AXIS_YAW   = 2;

    // report layout
    localparam int                 REPORT_BYTES = 6;
    localparam logic [BYTE_BITS-1:0] HIGH_MASK  = 8'hFC;

    // config registers
    localparam int WEIGHT_BITS      = 17;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int TRIG_BITS        = READING_BITS;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = WEIGHT_BITS;

    localparam logic [WEIGHT_BITS-1:0] Q16_ONE         = WEIGHT_BITS'(1 << WEIGHT_FRAC_BITS);
    localparam logic                   RST_SMOOTH_EN   = 1'b1;
    localparam logic [WEIGHT_BITS-1:0] RST_WEIGHT      = WEIGHT_BITS'(58982);
    localparam logic [TRIG_BITS-1:0]   RST_TRIGGER     = TRIG_BITS'(5000);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SMOOTH_EN     = 2'd0,
        REG_SMOOTH_WEIGHT = 2'd1,
        REG_CAL_TRIGGER   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                   enable;
        logic [WEIGHT_BITS-1:0] weight;
        logic [TRIG_BITS-1:0]   trigger;
    } smooth_cfg_t;

    // smoothing multiply: signed weight times signed deviation
    localparam int SMOOTH_PROD_BITS = (WEIGHT_BITS + 1) + (READING_BITS + 1);

    // rate conversion
    localparam int SLOW_DIVISOR = 20;
    localparam int FAST_DIVISOR = 4;
    localparam int FAST_SHIFT   = $clog2(FAST_DIVISOR);
    localparam int MAG_BITS     = READING_BITS + RATE_FRACTION_BITS;
    localparam int DIV_SHIFT    = MAG_BITS + $clog2(SLOW_DIVISOR);
    localparam int RECIP_BITS   = MAG_BITS + 1;
    localparam int DIV_PROD_BITS = MAG_BITS + RECIP_BITS;
    localparam longint SLOW_RECIP_FULL =
        ((longint'(1) << DIV_SHIFT) + longint'(SLOW_DIVISOR) - 1) / longint'(SLOW_DIVISOR);
    localparam logic [RECIP_BITS-1:0] SLOW_RECIP = RECIP_BITS'(SLOW_RECIP_FULL);

    localparam int CMP_BITS = ((MAG_BITS > RATE_BITS) ? MAG_BITS : RATE_BITS) + 1;
    localparam logic [CMP_BITS-1:0] RATE_POS_LIMIT =
        CMP_BITS'((longint'(1) << (RATE_BITS - 1)) - 1);
    localparam logic [CMP_BITS-1:0] RATE_NEG_LIMIT =
        CMP_BITS'(longint'(1) << (RATE_BITS - 1));

    // stream widths
    localparam int S_TDATA_BITS = REPORT_BYTES * BYTE_BITS;
    localparam int RESULT_BITS  = 2 * AXES * RATE_BITS;
    localparam int M_TDATA_BITS = ((RESULT_BITS + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
    localparam int M_TUSER_BITS = AXES + 1;
    localparam int CAL_BIT      = AXES;

    typedef logic [READING_BITS-1:0]      reading_t;
    typedef logic signed [READING_BITS:0] diff_t;
    typedef logic signed [RATE_BITS-1:0]  rate_t;

    function automatic reading_t unpack_reading(input logic [BYTE_BITS-1:0] high_byte,
                                                input logic [BYTE_BITS-1:0] low_byte);
        unpack_reading = (reading_t'(high_byte & HIGH_MASK) << (READING_BITS - BYTE_BITS))
                       | reading_t'(low_byte);
    endfunction

endpackage

`default_nettype wire

/* rtl/gyro_report_decode_smooth_core.sv */
`default_nettype none

// channel   dir  beat accepted on             payload
// s_        in   s_tvalid & s_tready          tdata: report bytes 0..5
// m_        out  m_tvalid & m_tready          tdata: six rates, tuser: flags
// cfg_      in   cfg_valid & cfg_ready        cfg_index, cfg_data
//
// one report per cycle sustained while m_tready stays high; a result passes the input register,
// the tracking register and the rate register before it shows on m_
// the offset/smoothing recurrence closes through one multiplier per axis
// back-pressure walks the valid chain: a stage loads when it is empty or moves on
// synchronous active-low reset clears valids, offsets, smoothed readings, loads defaults
// cfg_ready is always high; write only while no beat is in flight

module gyro_report_decode_smooth_core import grds_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // report_byte_0 .. report_byte_5, byte 0 lowest
    input  wire logic [S_TDATA_BITS-1:0]   s_tdata,

    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // roll_rate_raw, pitch_rate_raw, yaw_rate_raw, roll_rate_smooth,
    // pitch_rate_smooth, yaw_rate_smooth, zero pad at top
    output logic [M_TDATA_BITS-1:0]        m_tdata,
    // slow_flags [2:0], calibrated_now [3]
    output logic [M_TUSER_BITS-1:0]        m_tuser,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // config registers
    smooth_cfg_t cfg_reg;
    smooth_cfg_t cfg_next;

    // stage a: raw report
    logic                     a_vld_reg;
    logic [S_TDATA_BITS-1:0]  a_data_reg;

    // stage b: readings with offsets and smoothed values
    logic                     b_vld_reg;
    reading_t                 b_read_reg   [AXES];
    reading_t                 b_off_reg    [AXES];
    reading_t                 b_smooth_reg [AXES];
    logic [AXES-1:0]          b_slow_reg;
    logic                     b_cal_reg;

    // stage c: result beat
    logic                     c_vld_reg;
    rate_t                    c_raw_reg    [AXES];
    rate_t                    c_smooth_reg [AXES];
    logic [AXES-1:0]          c_slow_reg;
    logic                     c_cal_reg;

    logic                     a_ready;
    logic                     b_ready;
    logic                     c_ready;

    logic [BYTE_BITS-1:0]     rep          [REPORT_BYTES];
    reading_t                 rd           [AXES];
    logic [AXES-1:0]          slow;
    reading_t                 offset_next  [AXES];
    reading_t                 smooth_next  [AXES];
    logic                     cal_next;
    diff_t                    raw_diff     [AXES];
    diff_t                    smooth_diff  [AXES];
    rate_t                    raw_rate     [AXES];
    rate_t                    smooth_rate  [AXES];

    // ---------------------------------------------------------------- config port
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_SMOOTH_EN:     cfg_next.enable  = cfg_data[0];
                REG_SMOOTH_WEIGHT: cfg_next.weight  = cfg_data[WEIGHT_BITS-1:0];
                REG_CAL_TRIGGER:   cfg_next.trigger = cfg_data[TRIG_BITS-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable  <= RST_SMOOTH_EN;
            cfg_reg.weight  <= RST_WEIGHT;
            cfg_reg.trigger <= RST_TRIGGER;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------- flow control
    // a stage takes a new beat when empty or when its content moves on
    assign c_ready  = !c_vld_reg || m_tready;
    assign b_ready  = !b_vld_reg || c_ready;
    assign a_ready  = !a_vld_reg || b_ready;
    assign s_tready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            if (a_ready) a_vld_reg <= s_tvalid;
            if (b_ready) b_vld_reg <= a_vld_reg;
            if (c_ready) c_vld_reg <= b_vld_reg;
        end
    end

    // ---------------------------------------------------------------- stage a
    always_ff @(posedge aclk) begin
        if (s_tvalid && a_ready) a_data_reg <= s_tdata;
    end

    // unpack the six bytes
    always_comb begin
        for (int i = 0; i < REPORT_BYTES; i++) begin
            rep[i] = a_data_reg[i*BYTE_BITS +: BYTE_BITS];
        end
        rd[AXIS_ROLL]    = unpack_reading(rep[4], rep[1]);
        rd[AXIS_PITCH]   = unpack_reading(rep[5], rep[2]);
        rd[AXIS_YAW]     = unpack_reading(rep[3], rep[0]);
        slow[AXIS_ROLL]  = rep[4][1];
        slow[AXIS_PITCH] = rep[3][0];
        slow[AXIS_YAW]   = rep[3][1];
    end

    // state advances only when the report actually moves into stage b
    grds_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .upd         (a_vld_reg && b_ready),
        .cfg         (cfg_reg),
        .rd          (rd),
        .offset_next (offset_next),
        .smooth_next (smooth_next),
        .cal_next    (cal_next)
    );

    // ---------------------------------------------------------------- stage b
    always_ff @(posedge aclk) begin
        if (b_ready) begin
            for (int i = 0; i < AXES; i++) begin
                b_read_reg[i]   <= rd[i];
                b_off_reg[i]    <= offset_next[i];
                b_smooth_reg[i] <= smooth_next[i];
            end
            // flags word: bit2 roll, bit1 pitch, bit0 yaw
            b_slow_reg <= {slow[AXIS_ROLL], slow[AXIS_PITCH], slow[AXIS_YAW]};
            b_cal_reg  <= cal_next;
        end
    end

    // ---------------------------------------------------------------- rates
    for (genvar g = 0; g < AXES; g++) begin : g_axis
        assign raw_diff[g]    = $signed({1'b0, b_read_reg[g]})   - $signed({1'b0, b_off_reg[g]});
        assign smooth_diff[g] = $signed({1'b0, b_smooth_reg[g]}) - $signed({1'b0, b_off_reg[g]});

        grds_rate u_raw (
            .diff (raw_diff[g]),
            .slow (b_slow_reg[AXES-1-g]),
            .rate (raw_rate[g])
        );

        grds_rate u_smooth (
            .diff (smooth_diff[g]),
            .slow (b_slow_reg[AXES-1-g]),
            .rate (smooth_rate[g])
        );
    end

    // ---------------------------------------------------------------- stage c
    always_ff @(posedge aclk) begin
        if (c_ready) begin
            for (int i = 0; i < AXES; i++) begin
                c_raw_reg[i]    <= raw_rate[i];
                c_smooth_reg[i] <= smooth_rate[i];
            end
            c_slow_reg <= b_slow_reg;
            c_cal_reg  <= b_cal_reg;
        end
    end

    assign m_tvalid = c_vld_reg;
    assign m_tdata  = M_TDATA_BITS'({c_smooth_reg[AXIS_YAW], c_smooth_reg[AXIS_PITCH],
                                     c_smooth_reg[AXIS_ROLL], c_raw_reg[AXIS_YAW],
                                     c_raw_reg[AXIS_PITCH], c_raw_reg[AXIS_ROLL]});
    assign m_tuser  = {c_cal_reg, c_slow_reg};

endmodule

`default_nettype wire

/* rtl/grds_track.sv */
`default_nettype none

// offset capture and smoothing recurrence, one report per update
module grds_track import grds_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        upd,
    input  wire smooth_cfg_t cfg,
    input  wire reading_t    rd            [AXES],
    output reading_t         offset_next   [AXES],
    output reading_t         smooth_next   [AXES],
    output logic             cal_next
);

    reading_t                      offset_reg [AXES];
    reading_t                      smooth_reg [AXES];
    reading_t                      seed       [AXES];
    diff_t                         dev        [AXES];
    logic signed [SMOOTH_PROD_BITS-1:0] prod  [AXES];
    logic signed [SMOOTH_PROD_BITS-1:0] step  [AXES];
    logic [WEIGHT_BITS-1:0]        weight_clip;
    logic signed [WEIGHT_BITS:0]   weight_s;
    logic                          offs_zero;
    logic                          above;

    always_comb begin
        offs_zero = 1'b1;
        above     = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            offs_zero = offs_zero & (offset_reg[i] == '0);
            above     = above & (rd[i] > cfg.trigger);
        end
        cal_next = offs_zero & above;

        // weights above one hold the smoothed value
        weight_clip = (cfg.weight > Q16_ONE) ? Q16_ONE : cfg.weight;
        weight_s    = $signed({1'b0, weight_clip});

        // s' = r + floor(w * (s - r) / 2^16)
        for (int i = 0; i < AXES; i++) begin
            offset_next[i] = cal_next ? rd[i] : offset_reg[i];
            seed[i]        = cal_next ? rd[i] : smooth_reg[i];
            dev[i]         = $signed({1'b0, seed[i]}) - $signed({1'b0, rd[i]});
            prod[i]        = weight_s * dev[i];
            step[i]        = prod[i] >>> WEIGHT_FRAC_BITS;
            smooth_next[i] = cfg.enable ? (rd[i] + step[i][READING_BITS-1:0]) : rd[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                offset_reg[i] <= '0;
                smooth_reg[i] <= '0;
            end
        end else if (upd) begin
            for (int i = 0; i < AXES; i++) begin
                offset_reg[i] <= offset_next[i];
                smooth_reg[i] <= smooth_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/grds_rate.sv */
`default_nettype none

// (reading - offset) * 2^frac / 20 or / 4, toward zero, saturated
module grds_rate import grds_pkg::*; (
    input  wire diff_t  diff,
    input  wire logic   slow,
    output rate_t       rate
);

    logic                      neg;
    logic [READING_BITS-1:0]   mag;
    logic [MAG_BITS-1:0]       scaled;
    logic [DIV_PROD_BITS-1:0]  prod;
    logic [MAG_BITS-1:0]       quo;
    logic [CMP_BITS-1:0]       quo_w;
    logic [CMP_BITS-1:0]       limit;
    logic [RATE_BITS-1:0]      mag_sat;

    always_comb begin
        neg    = diff[READING_BITS];
        mag    = neg ? READING_BITS'(-diff) : READING_BITS'(diff);
        scaled = MAG_BITS'(mag) << RATE_FRACTION_BITS;
        // divide by 20 through a rounded-up reciprocal, exact over the magnitude range
        prod   = DIV_PROD_BITS'(scaled) * DIV_PROD_BITS'(SLOW_RECIP);
        quo    = slow ? MAG_BITS'(prod >> DIV_SHIFT) : (scaled >> FAST_SHIFT);
        quo_w  = CMP_BITS'(quo);
        limit  = neg ? RATE_NEG_LIMIT : RATE_POS_LIMIT;
        mag_sat = (quo_w > limit) ? RATE_BITS'(limit) : RATE_BITS'(quo_w);
        rate   = neg ? -$signed(mag_sat) : $signed(mag_sat);
    end

endmodule

`default_nettype wire

/* rtl/grds_checker.sv */
`default_nettype none

`include "gyro_report_decode_smooth_core_assert.svh"

module grds_checker import grds_pkg::*; (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [M_TDATA_BITS-1:0]   m_tdata,
    input wire logic [M_TUSER_BITS-1:0]   m_tuser
);

    // a stalled result beat stays up
    `GRDS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)

    // the pipeline only pushes back when every stage is full and the sink stalls
    `GRDS_ASSERT(a_in_stall, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready)

    // a capturing report zeroes its own raw and smoothed rates
    `GRDS_ASSERT(a_cal_zero, aclk, aresetn, m_tvalid && m_tuser[CAL_BIT] |-> m_tdata == '0)

    // reset empties the result register
    `GRDS_ASSERT_NORST(a_rst_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind gyro_report_decode_smooth_core grds_checker u_grds_checker (.*);

`default_nettype wire

/* test/tb_gyro_report_decode_smooth_core.sv */
`timescale 1ns / 100ps

module tb_gyro_report_decode_smooth_core;
    import grds_pkg::*;

    // beat reaches m_ three stages after it is taken
    localparam int PIPE_DEPTH = 3;
    localparam longint TIMEOUT_NS = 1_000_000;

    // index past the last register, the block must ignore it
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

    // saturation bounds of a signed rate field
    localparam longint RATE_HI = (longint'(1) << (RATE_BITS - 1)) - 1;
    localparam longint RATE_LO = -(longint'(1) << (RATE_BITS - 1));
    localparam longint unsigned WEIGHT_UNITY = 65536;

    // one expected result beat: six rates packed as on m_tdata, flags as on m_tuser
    typedef struct packed {
        logic [M_TDATA_BITS-1:0] rates;
        logic [M_TUSER_BITS-1:0] flags;
    } rate_beat_t;

    // tracks offsets, smoothed readings and register values; predicts each result beat
    class gyro_rate_tracker;
        reading_t               offset [AXES];
        reading_t               smoothed [AXES];
        logic                   smooth_on;
        logic [WEIGHT_BITS-1:0] weight;
        logic [TRIG_BITS-1:0]   trigger;
        rate_beat_t             pending_rates [$];
        int                     errors;
        string                  rate_names [2*AXES];

        function new();
            for (int a = 0; a < AXES; a++) begin
                offset[a]   = '0;
                smoothed[a] = '0;
            end
            smooth_on = 1'b1;
            weight    = WEIGHT_BITS'(58982);
            trigger   = TRIG_BITS'(5000);
            errors    = 0;
            rate_names = '{"roll_rate_raw", "pitch_rate_raw", "yaw_rate_raw",
                           "roll_rate_smooth", "pitch_rate_smooth", "yaw_rate_smooth"};
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_SMOOTH_EN:     smooth_on = data[0];
                REG_SMOOTH_WEIGHT: weight    = data[WEIGHT_BITS-1:0];
                REG_CAL_TRIGGER:   trigger   = data[TRIG_BITS-1:0];
                default: ;
            endcase
        endfunction

        // (reading - offset) scaled to fraction bits, divided, truncated toward zero
        static function rate_t to_rate(reading_t r, reading_t off, logic slow);
            longint q;
            q = ((longint'(r) - longint'(off)) * (longint'(1) << RATE_FRACTION_BITS))
                / (slow ? longint'(SLOW_DIVISOR) : longint'(FAST_DIVISOR));
            if (q > RATE_HI) q = RATE_HI;
            if (q < RATE_LO) q = RATE_LO;
            return rate_t'(q);
        endfunction

        function void note_report(logic [S_TDATA_BITS-1:0] rpt);
            logic [BYTE_BITS-1:0] b [REPORT_BYTES];
            reading_t             rd [AXES];
            logic                 slow [AXES];
            logic                 capture;
            longint unsigned      w;
            longint unsigned      acc;
            rate_beat_t           beat;
            for (int k = 0; k < REPORT_BYTES; k++) b[k] = rpt[k*BYTE_BITS +: BYTE_BITS];
            // high six bits from the top of a shared byte, low eight from a byte of their own
            rd[AXIS_ROLL]  = {b[4][7:2], b[1]};
            rd[AXIS_PITCH] = {b[5][7:2], b[2]};
            rd[AXIS_YAW]   = {b[3][7:2], b[0]};
            slow[AXIS_ROLL]  = b[4][1];
            slow[AXIS_PITCH] = b[3][0];
            slow[AXIS_YAW]   = b[3][1];

            // first capture only while every offset is still zero
            capture = rd[AXIS_ROLL] > trigger && rd[AXIS_PITCH] > trigger &&
                      rd[AXIS_YAW] > trigger && offset[AXIS_ROLL] == '0 &&
                      offset[AXIS_PITCH] == '0 && offset[AXIS_YAW] == '0;
            if (capture) begin
                for (int a = 0; a < AXES; a++) begin
                    offset[a]   = rd[a];
                    smoothed[a] = rd[a];
                end
            end

            // weight above one holds the smoothed value
            w = (longint'(weight) > longint'(WEIGHT_UNITY)) ? WEIGHT_UNITY : longint'(weight);
            for (int a = 0; a < AXES; a++) begin
                if (smooth_on) begin
                    acc = w * smoothed[a] + (WEIGHT_UNITY - w) * rd[a];
                    smoothed[a] = reading_t'(acc >> WEIGHT_FRAC_BITS);
                end else begin
                    smoothed[a] = rd[a];
                end
            end

            beat.rates = '0;
            for (int a = 0; a < AXES; a++) begin
                beat.rates[a*RATE_BITS +: RATE_BITS] = to_rate(rd[a], offset[a], slow[a]);
                beat.rates[(AXES+a)*RATE_BITS +: RATE_BITS] =
                    to_rate(smoothed[a], offset[a], slow[a]);
            end
            beat.flags = {capture, slow[AXIS_ROLL], slow[AXIS_PITCH], slow[AXIS_YAW]};
            pending_rates.push_back(beat);
        endfunction

        function void check_rates(logic [M_TDATA_BITS-1:0] data, logic [M_TUSER_BITS-1:0] user);
            rate_beat_t want;
            rate_t      e;
            rate_t      g;
            if (pending_rates.size() == 0) begin
                $error("result beat with no report pending: tdata=%h tuser=%h", data, user);
                errors++;
                return;
            end
            want = pending_rates.pop_front();
            for (int k = 0; k < 2*AXES; k++) begin
                e = want.rates[k*RATE_BITS +: RATE_BITS];
                g = data[k*RATE_BITS +: RATE_BITS];
                if (e !== g) begin
                    $error("%s: expected %0d, got %0d", rate_names[k], e, g);
                    errors++;
                end
            end
            if (want.flags[AXES-1:0] !== user[AXES-1:0]) begin
                $error("slow_flags: expected %0d, got %0d", want.flags[AXES-1:0], user[AXES-1:0]);
                errors++;
            end
            if (want.flags[CAL_BIT] !== user[CAL_BIT]) begin
                $error("calibrated_now: expected %0d, got %0d", want.flags[CAL_BIT], user[CAL_BIT]);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic [M_TUSER_BITS-1:0]   m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    gyro_rate_tracker tracker;
    // set for the closing phase: no stalls on either side
    bit               calm = 1'b0;
    // slowly wandering readings, so smoothing sees realistic sequences
    reading_t         walk [AXES];

    gyro_report_decode_smooth_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // builds a report; slow_bits is {roll, pitch, yaw}; spare fills the unused bits
    function automatic logic [S_TDATA_BITS-1:0] pack_report(reading_t roll, reading_t pitch,
                                                            reading_t yaw,
                                                            logic [AXES-1:0] slow_bits,
                                                            logic [2:0] spare);
        return {pitch[READING_BITS-1:BYTE_BITS], spare[1:0],
                roll[READING_BITS-1:BYTE_BITS], slow_bits[2], spare[2],
                yaw[READING_BITS-1:BYTE_BITS], slow_bits[0], slow_bits[1],
                pitch[BYTE_BITS-1:0], roll[BYTE_BITS-1:0], yaw[BYTE_BITS-1:0]};
    endfunction

    // mostly wandering readings with random flags, the rest raw noise
    function automatic logic [S_TDATA_BITS-1:0] random_report();
        int v;
        if ($urandom_range(0, 9) < 3) return S_TDATA_BITS'({$urandom, $urandom});
        for (int a = 0; a < AXES; a++) begin
            if ($urandom_range(0, 31) == 0) begin
                // occasional jump, often to a rail
                if ($urandom_range(0, 2) == 0)
                    walk[a] = $urandom_range(0, 1) ? '1 : '0;
                else
                    walk[a] = reading_t'($urandom);
            end else begin
                v = int'(walk[a]) + int'($urandom_range(0, 96)) - 48;
                if (v < 0) v = 0;
                if (v > (1 << READING_BITS) - 1) v = (1 << READING_BITS) - 1;
                walk[a] = reading_t'(v);
            end
        end
        return pack_report(walk[AXIS_ROLL], walk[AXIS_PITCH], walk[AXIS_YAW],
                           AXES'($urandom), 3'($urandom));
    endfunction

    // holds the beat until taken; valid stays high for a following beat
    task automatic send_report(input logic [S_TDATA_BITS-1:0] rpt);
        s_tdata  <= rpt;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_report(rpt);
    endtask

    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // stop sending and wait for every predicted beat, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_rates.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH) @(posedge aclk);
    endtask

    // valid drops after each write and stays low before the next, for a clean edge
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // gap_pct: chance in percent of a sender gap before a beat
    task automatic run_random(input int count, input int gap_pct);
        for (int i = 0; i < count; i++) begin
            if (!calm && $urandom_range(1, 100) <= gap_pct) pause_sender($urandom_range(1, 14));
            send_report(random_report());
        end
    endtask

    // result side: random ready stretches broken by random stalls
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if (!calm) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    end

    // every accepted result beat goes to the checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_rates(m_tdata, m_tuser);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        tracker = new();
        for (int a = 0; a < AXES; a++) walk[a] = reading_t'($urandom);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // trigger at its top (upper data bits dropped): nothing can exceed it
        write_reg(REG_CAL_TRIGGER, '1);
        send_report(pack_report('0, '0, '0, 3'b000, 3'b000));
        send_report('1);
        send_report(pack_report('1, '1, '1, 3'b000, 3'b000));
        send_report(pack_report('0, '1, '0, 3'b111, 3'b111));
        send_report(pack_report('1, '0, '1, 3'b010, 3'b000));
        drain();

        // trigger zero, only bits above its width set: a zero reading still blocks capture
        write_reg(REG_CAL_TRIGGER, CFG_DATA_BITS'(17'h1C000));
        send_report(pack_report('0, '0, '0, 3'b001, 3'b000));
        send_report(pack_report(14'd1, 14'd1, '0, 3'b100, 3'b010));
        send_report(pack_report('0, 14'd1, 14'd1, 3'b000, 3'b101));
        drain();

        // readings equal to the trigger do not count as exceeding it
        write_reg(REG_CAL_TRIGGER, CFG_DATA_BITS'(5000));
        send_report(pack_report(14'd5000, 14'd5001, 14'd5001, 3'b000, 3'b000));
        send_report(pack_report(14'd5001, 14'd5000, 14'd16383, 3'b011, 3'b000));
        drain();

        // write to an unmapped index must change nothing
        write_reg(REG_UNMAPPED, '0);
        send_report(pack_report(14'd100, 14'd100, 14'd100, 3'b000, 3'b000));
        // offset capture, then no second capture; readings on both rails
        send_report(pack_report(14'd5001, 14'd9000, 14'd16383, 3'b101, 3'b000));
        send_report(pack_report('1, '1, '1, 3'b000, 3'b000));
        send_report(pack_report('0, '0, '0, 3'b111, 3'b000));
        send_report(pack_report('0, '0, '0, 3'b000, 3'b111));
        send_report(pack_report('1, '1, '1, 3'b111, 3'b000));
        send_report(pack_report(14'd5001, 14'd9000, 14'd16383, 3'b000, 3'b000));
        send_report(S_TDATA_BITS'({$urandom, $urandom}));
        // each phase below starts with the sender held until every result is back
        drain();

        // default weight, enable written with junk above bit 0
        write_reg(REG_SMOOTH_EN, {16'($urandom), 1'b1});
        run_random(120, 30);
        drain();

        // smoothing off: smoothed follows raw
        write_reg(REG_SMOOTH_EN, {16'($urandom), 1'b0});
        run_random(120, 0);
        drain();

        // smoothing on, zero weight: smoothed equals the new reading
        write_reg(REG_SMOOTH_EN, CFG_DATA_BITS'(1));
        write_reg(REG_SMOOTH_WEIGHT, '0);
        run_random(120, 50);
        drain();

        // weight of exactly one: smoothed holds
        write_reg(REG_SMOOTH_WEIGHT, CFG_DATA_BITS'(65536));
        run_random(120, 20);
        drain();

        // weight above one clamps to one; trigger moves but capture is long done
        write_reg(REG_SMOOTH_WEIGHT, '1);
        write_reg(REG_CAL_TRIGGER, CFG_DATA_BITS'($urandom));
        run_random(120, 40);
        drain();

        write_reg(REG_SMOOTH_WEIGHT, CFG_DATA_BITS'($urandom_range(0, 65536)));
        run_random(120, 10);
        drain();

        write_reg(REG_SMOOTH_WEIGHT, CFG_DATA_BITS'($urandom));
        write_reg(REG_CAL_TRIGGER, '0);
        run_random(120, 30);
        drain();

        // closing phase at reset defaults, both sides at full rate
        write_reg(REG_SMOOTH_WEIGHT, CFG_DATA_BITS'(58982));
        write_reg(REG_CAL_TRIGGER, CFG_DATA_BITS'(5000));
        calm = 1'b1;
        run_random(120, 0);
        drain();
        repeat (4 * PIPE_DEPTH) @(posedge aclk);

        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/grds_pkg.sv
rtl/grds_track.sv
rtl/grds_rate.sv
rtl/gyro_report_decode_smooth_core.sv
rtl/grds_checker.sv
test/tb_gyro_report_decode_smooth_core.sv
